>>> rtl/trdt_pkg.sv
package trdt_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 1024;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  localparam logic [11:0] FW_RESET = 12'd1280;
  localparam logic [10:0] FH_RESET = 11'd720;

  // register index taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // edge pairs
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // divider widths
  localparam int DEN_W = 50;
  localparam int NUM_W = 49;
  localparam int QUO_W = 49;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] WEIGHT_BITS = CNT_W'(16);
  localparam logic [CNT_W-1:0] LONG_BITS   = CNT_W'(49);

  localparam int IN_W  = 192;
  localparam int OUT_W = 112;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STEP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIV_WEIGHT = 2'd0,
    DIV_RECIP  = 2'd1,
    DIV_DEPTH  = 2'd2
  } div_kind_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_AREA,
    ST_EDGE,
    ST_COVER,
    ST_W_START,
    ST_W_RUN,
    ST_R_START,
    ST_R_RUN,
    ST_D_START,
    ST_D_RUN,
    ST_INDEX,
    ST_READ,
    ST_TEST,
    ST_RESULT,
    ST_EMPTY_RESULT
  } state_e;

  typedef struct packed {
    logic      in_ready;
    logic      load;
    logic      prod_en;
    logic [1:0] prod_sel;
    logic      point_cursor;
    logic      area_en;
    logic      edge_en;
    logic [1:0] edge_slot;
    logic      cov_en;
    logic      div_start;
    div_kind_e div_kind;
    logic [1:0] div_idx;
    logic      w_en;
    logic      s_en;
    logic      d_en;
    logic      idx_en;
    logic      rd_en;
    logic      wr_en;
    logic      res_load;
    logic      res_empty;
    logic      sweep_en;
  } cmd_t;

  typedef struct packed {
    logic cov;
    logic active;
    logic div_busy;
    logic div_done;
    logic out_busy;
    logic sweep_last;
  } sts_t;

endpackage

>>> rtl/trdt_div.sv
module trdt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [trdt_pkg::DEN_W-1:0]    rem_init_i,
  input  logic [trdt_pkg::NUM_W-1:0]    num_i,
  input  logic [trdt_pkg::DEN_W-1:0]    den_i,
  input  logic [trdt_pkg::CNT_W-1:0]    count_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [trdt_pkg::QUO_W-1:0]    quo_o
);

  logic [trdt_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [trdt_pkg::NUM_W-1:0] num_q;
  logic [trdt_pkg::DEN_W-1:0] den_q;
  logic [trdt_pkg::QUO_W-1:0] quo_q;
  logic [trdt_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic [trdt_pkg::DEN_W:0]   shifted, diff;
  logic                       ge;

  // restoring step, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, num_q[trdt_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[trdt_pkg::DEN_W-1:0] : shifted[trdt_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == trdt_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[trdt_pkg::NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[trdt_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/trdt_datapath.sv
module trdt_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trdt_pkg::cmd_t              cmd_i,
  output trdt_pkg::sts_t              sts_o,
  input  logic [trdt_pkg::IN_W-1:0]   in_data_i,
  input  logic [11:0]                 frame_width_i,
  input  logic [10:0]                 frame_height_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [trdt_pkg::OUT_W-1:0]  out_data_o,
  output logic                        out_last_o
);

  logic signed [15:0] vx_q [3];
  logic signed [15:0] vy_q [3];
  logic [31:0]        vz_q [3];
  logic signed [15:0] ix [3];
  logic signed [15:0] iy [3];

  logic [34:0]        area_q;
  logic signed [11:0] box_x0_q, box_y0_q, cur_x_q, cur_y_q;
  logic signed [15:0] box_xmax_q, box_ymax_q;
  logic               active_q;

  logic signed [15:0] pxv, pyv, qxv, qyv, ptx, pty;
  logic signed [16:0] dqx, dpy, dqy, dpx;
  logic signed [33:0] prod1_q, prod2_q;
  logic signed [34:0] edge_diff;
  logic signed [34:0] edge_q [3];

  logic               cov_q, pass_q, cov_now;
  logic [16:0]        w_q [3];
  logic [49:0]        s_q;
  logic [31:0]        d_q;

  logic               inframe_q;
  logic [23:0]        idx_q;
  logic               addr_ok;
  logic [31:0]        rd_q;
  logic               wr_hit;
  logic [trdt_pkg::ADDR_W-1:0] sweep_q;

  logic [trdt_pkg::DEN_W-1:0] div_rem, div_den;
  logic [trdt_pkg::NUM_W-1:0] div_num;
  logic [trdt_pkg::CNT_W-1:0] div_cnt;
  logic [trdt_pkg::QUO_W-1:0] quo;
  logic                       div_busy, div_done;
  logic [34:0]                wsel_abs;

  logic signed [15:0] min_x, min_y, max_x, max_y;
  logic signed [11:0] t_x0, t_y0;
  logic signed [12:0] ny, nx;
  logic signed [16:0] ny16, nx16;
  logic               adv_y, adv_x;

  logic               out_valid_q;
  logic [trdt_pkg::OUT_W-1:0] out_data_q;
  logic               out_last_q;

  logic [31:0] depth_mem [trdt_pkg::STORE_SIZE];

  function automatic logic signed [15:0] min2(logic signed [15:0] a, logic signed [15:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [15:0] max2(logic signed [15:0] a, logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

  // truncate Q12.4 toward zero
  function automatic logic signed [11:0] trunc_q4(logic signed [15:0] v);
    logic [16:0] mag;
    logic [12:0] t;
    logic [12:0] r;
    mag = v[15] ? (17'd0 - {v[15], v}) : {v[15], v};
    t   = mag[16:4];
    r   = v[15] ? (13'd0 - t) : t;
    return r[11:0];
  endfunction

  function automatic logic [34:0] abs35(logic signed [34:0] v);
    return v[34] ? (35'd0 - v) : v;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ix[i] = in_data_i[64*i +: 16];
      iy[i] = in_data_i[64*i+16 +: 16];
    end
    min_x = min2(min2(ix[0], ix[1]), ix[2]);
    min_y = min2(min2(iy[0], iy[1]), iy[2]);
    max_x = max2(max2(ix[0], ix[1]), ix[2]);
    max_y = max2(max2(iy[0], iy[1]), iy[2]);
    t_x0  = trunc_q4(min_x);
    t_y0  = trunc_q4(min_y);
  end

  // load and traversal control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
        vz_q[i] <= '0;
      end
      box_x0_q   <= '0;
      box_y0_q   <= '0;
      box_xmax_q <= '0;
      box_ymax_q <= '0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      active_q   <= 1'b0;
      area_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        for (int i = 0; i < 3; i++) begin
          vx_q[i] <= ix[i];
          vy_q[i] <= iy[i];
          vz_q[i] <= (in_data_i[64*i+32 +: 32] == 32'd0) ? 32'd1 : in_data_i[64*i+32 +: 32];
        end
        box_x0_q   <= t_x0;
        box_y0_q   <= t_y0;
        box_xmax_q <= max_x;
        box_ymax_q <= max_y;
        cur_x_q    <= t_x0;
        cur_y_q    <= t_y0;
        active_q   <= ($signed({t_x0, 4'b0}) < max_x) && ($signed({t_y0, 4'b0}) < max_y);
      end
      if (cmd_i.area_en) begin
        area_q <= abs35(edge_diff);
      end
      if (cmd_i.res_load && !cmd_i.res_empty) begin
        if (adv_y) begin
          cur_y_q <= ny[11:0];
        end else begin
          cur_y_q <= box_y0_q;
          if (adv_x) begin
            cur_x_q <= nx[11:0];
          end else begin
            active_q <= 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    ny    = 13'(cur_y_q) + 13'sd1;
    nx    = 13'(cur_x_q) + 13'sd1;
    ny16  = {ny, 4'b0};
    nx16  = {nx, 4'b0};
    adv_y = ny16 < 17'(box_ymax_q);
    adv_x = nx16 < 17'(box_xmax_q);
  end

  // edge function, products then difference
  always_comb begin
    case (cmd_i.prod_sel)
      trdt_pkg::EDGE_AB: begin
        pxv = vx_q[0]; pyv = vy_q[0]; qxv = vx_q[1]; qyv = vy_q[1];
      end
      trdt_pkg::EDGE_BC: begin
        pxv = vx_q[1]; pyv = vy_q[1]; qxv = vx_q[2]; qyv = vy_q[2];
      end
      trdt_pkg::EDGE_CA: begin
        pxv = vx_q[2]; pyv = vy_q[2]; qxv = vx_q[0]; qyv = vy_q[0];
      end
      default: begin
        pxv = vx_q[0]; pyv = vy_q[0]; qxv = vx_q[1]; qyv = vy_q[1];
      end
    endcase
    ptx = cmd_i.point_cursor ? {cur_x_q, 4'b0} : vx_q[2];
    pty = cmd_i.point_cursor ? {cur_y_q, 4'b0} : vy_q[2];
    dqx = 17'(qxv) - 17'(pxv);
    dpy = 17'(pty) - 17'(pyv);
    dqy = 17'(qyv) - 17'(pyv);
    dpx = 17'(ptx) - 17'(pxv);
    edge_diff = 35'(prod1_q) - 35'(prod2_q);
    cov_now = (edge_q[0] > 0 && edge_q[1] > 0 && edge_q[2] > 0) ||
              (edge_q[0] < 0 && edge_q[1] < 0 && edge_q[2] < 0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod1_q <= dqx * dpy;
      prod2_q <= dqy * dpx;
    end
    if (cmd_i.edge_en) begin
      edge_q[cmd_i.edge_slot] <= edge_diff;
    end
  end

  // divider operands
  always_comb begin
    case (cmd_i.div_idx)
      2'd0:    wsel_abs = abs35(edge_q[trdt_pkg::EDGE_BC]);
      2'd1:    wsel_abs = abs35(edge_q[trdt_pkg::EDGE_CA]);
      default: wsel_abs = abs35(edge_q[trdt_pkg::EDGE_AB]);
    endcase
    case (cmd_i.div_kind)
      trdt_pkg::DIV_WEIGHT: begin
        div_rem = trdt_pkg::DEN_W'(wsel_abs);
        div_num = '0;
        div_den = trdt_pkg::DEN_W'(area_q);
        div_cnt = trdt_pkg::WEIGHT_BITS;
      end
      trdt_pkg::DIV_RECIP: begin
        div_rem = '0;
        div_num = {w_q[cmd_i.div_idx], 32'd0};
        div_den = trdt_pkg::DEN_W'(vz_q[cmd_i.div_idx]);
        div_cnt = trdt_pkg::LONG_BITS;
      end
      trdt_pkg::DIV_DEPTH: begin
        div_rem = '0;
        div_num = {1'b1, 48'd0};
        div_den = s_q;
        div_cnt = trdt_pkg::LONG_BITS;
      end
      default: begin
        div_rem = '0;
        div_num = '0;
        div_den = '0;
        div_cnt = trdt_pkg::WEIGHT_BITS;
      end
    endcase
  end

  trdt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem),
    .num_i      (div_num),
    .den_i      (div_den),
    .count_i    (div_cnt),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cov_en) begin
      cov_q <= cov_now;
      s_q   <= '0;
    end
    if (cmd_i.w_en) begin
      w_q[cmd_i.div_idx] <= (quo > trdt_pkg::QUO_W'(65536)) ? 17'd65536 : quo[16:0];
    end
    if (cmd_i.s_en) begin
      s_q <= s_q + 50'(quo);
    end
    if (cmd_i.d_en) begin
      if (s_q == '0 || quo[48:32] != '0) begin
        d_q <= 32'hFFFF_FFFF;
      end else if (quo == '0) begin
        d_q <= 32'd1;
      end else begin
        d_q <= quo[31:0];
      end
    end
    if (cmd_i.idx_en) begin
      inframe_q <= !cur_x_q[11] && !cur_y_q[11] &&
                   ({1'b0, cur_x_q[10:0]} < frame_width_i) &&
                   (cur_y_q[10:0] < frame_height_i);
      idx_q     <= 24'(cur_y_q[10:0] * frame_width_i) + 24'(cur_x_q[10:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
    end else if (cmd_i.cov_en) begin
      pass_q <= 1'b0;
    end else if (wr_hit) begin
      pass_q <= 1'b1;
    end
  end

  assign addr_ok = inframe_q && ({1'b0, idx_q} < 25'(trdt_pkg::STORE_SIZE));
  assign wr_hit  = cmd_i.wr_en && cov_q && addr_ok && (rd_q == '0 || rd_q > d_q);

  // depth store, swept to zero after reset and on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_en) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_en) begin
      depth_mem[sweep_q] <= '0;
    end else if (wr_hit) begin
      depth_mem[idx_q[trdt_pkg::ADDR_W-1:0]] <= d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= depth_mem[idx_q[trdt_pkg::ADDR_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (cmd_i.res_empty) begin
        out_data_q <= '0;
        out_last_q <= 1'b1;
      end else begin
        out_data_q <= {3'b0,
                       cov_q ? w_q[2] : 17'd0,
                       cov_q ? w_q[1] : 17'd0,
                       cov_q ? w_q[0] : 17'd0,
                       cov_q ? d_q : 32'd0,
                       pass_q,
                       cov_q,
                       cur_y_q,
                       cur_x_q};
        out_last_q <= !adv_y && !adv_x;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  assign sts_o.cov        = cov_now;
  assign sts_o.active     = active_q;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.sweep_last = sweep_q == trdt_pkg::ADDR_W'(trdt_pkg::STORE_SIZE - 1);

endmodule

>>> rtl/trdt_ctrl.sv
module trdt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      op_i,
  input  trdt_pkg::sts_t  sts_i,
  output trdt_pkg::cmd_t  cmd_o
);

  trdt_pkg::state_e state_q, state_d;
  logic [1:0]       k_q, k_d;
  trdt_pkg::op_e    op;

  assign op = trdt_pkg::op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trdt_pkg::ST_CLEAR;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      trdt_pkg::ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = trdt_pkg::ST_IDLE;
      end
      trdt_pkg::ST_IDLE: begin
        k_d = '0;
        if (in_valid_i) begin
          case (op)
            trdt_pkg::OP_LOAD:  state_d = trdt_pkg::ST_LOAD_MUL;
            trdt_pkg::OP_STEP:  state_d = sts_i.active ? trdt_pkg::ST_EDGE
                                                       : trdt_pkg::ST_EMPTY_RESULT;
            trdt_pkg::OP_CLEAR: state_d = trdt_pkg::ST_CLEAR;
            default:            state_d = trdt_pkg::ST_IDLE;
          endcase
        end
      end
      trdt_pkg::ST_LOAD_MUL:  state_d = trdt_pkg::ST_LOAD_AREA;
      trdt_pkg::ST_LOAD_AREA: state_d = trdt_pkg::ST_IDLE;
      trdt_pkg::ST_EDGE: begin
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          k_d     = '0;
          state_d = trdt_pkg::ST_COVER;
        end
      end
      trdt_pkg::ST_COVER: begin
        state_d = sts_i.cov ? trdt_pkg::ST_W_START : trdt_pkg::ST_RESULT;
      end
      trdt_pkg::ST_W_START: state_d = trdt_pkg::ST_W_RUN;
      trdt_pkg::ST_W_RUN: begin
        if (sts_i.div_done) begin
          k_d     = (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
          state_d = (k_q == 2'd2) ? trdt_pkg::ST_R_START : trdt_pkg::ST_W_START;
        end
      end
      trdt_pkg::ST_R_START: state_d = trdt_pkg::ST_R_RUN;
      trdt_pkg::ST_R_RUN: begin
        if (sts_i.div_done) begin
          k_d     = (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
          state_d = (k_q == 2'd2) ? trdt_pkg::ST_D_START : trdt_pkg::ST_R_START;
        end
      end
      trdt_pkg::ST_D_START: state_d = trdt_pkg::ST_D_RUN;
      trdt_pkg::ST_D_RUN: begin
        if (sts_i.div_done) state_d = trdt_pkg::ST_INDEX;
      end
      trdt_pkg::ST_INDEX: state_d = trdt_pkg::ST_READ;
      trdt_pkg::ST_READ:  state_d = trdt_pkg::ST_TEST;
      trdt_pkg::ST_TEST:  state_d = trdt_pkg::ST_RESULT;
      trdt_pkg::ST_RESULT, trdt_pkg::ST_EMPTY_RESULT: begin
        if (!sts_i.out_busy) state_d = trdt_pkg::ST_IDLE;
      end
      default: state_d = trdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_kind = trdt_pkg::DIV_WEIGHT;
    cmd_o.div_idx  = k_q;
    case (state_q)
      trdt_pkg::ST_CLEAR: cmd_o.sweep_en = 1'b1;
      trdt_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i && (op == trdt_pkg::OP_LOAD);
      end
      trdt_pkg::ST_LOAD_MUL: begin
        cmd_o.prod_en  = 1'b1;
        cmd_o.prod_sel = trdt_pkg::EDGE_AB;
      end
      trdt_pkg::ST_LOAD_AREA: cmd_o.area_en = 1'b1;
      trdt_pkg::ST_EDGE: begin
        // products for edge k, difference for edge k-1
        cmd_o.prod_en      = (k_q != 2'd3);
        cmd_o.prod_sel     = k_q;
        cmd_o.point_cursor = 1'b1;
        cmd_o.edge_en      = (k_q != 2'd0);
        cmd_o.edge_slot    = k_q - 1'b1;
      end
      trdt_pkg::ST_COVER: cmd_o.cov_en = 1'b1;
      trdt_pkg::ST_W_START: cmd_o.div_start = 1'b1;
      trdt_pkg::ST_W_RUN: cmd_o.w_en = sts_i.div_done;
      trdt_pkg::ST_R_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = trdt_pkg::DIV_RECIP;
      end
      trdt_pkg::ST_R_RUN: begin
        cmd_o.div_kind = trdt_pkg::DIV_RECIP;
        cmd_o.s_en     = sts_i.div_done;
      end
      trdt_pkg::ST_D_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = trdt_pkg::DIV_DEPTH;
      end
      trdt_pkg::ST_D_RUN: begin
        cmd_o.div_kind = trdt_pkg::DIV_DEPTH;
        cmd_o.d_en     = sts_i.div_done;
      end
      trdt_pkg::ST_INDEX: cmd_o.idx_en = 1'b1;
      trdt_pkg::ST_READ:  cmd_o.rd_en  = 1'b1;
      trdt_pkg::ST_TEST:  cmd_o.wr_en  = 1'b1;
      trdt_pkg::ST_RESULT: cmd_o.res_load = !sts_i.out_busy;
      trdt_pkg::ST_EMPTY_RESULT: begin
        cmd_o.res_load  = !sts_i.out_busy;
        cmd_o.res_empty = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_test_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> $past(cmd_o.rd_en))
    else $error("depth test without a preceding read");

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> !sts_i.out_busy)
    else $error("result overwritten before it was taken");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep_en |-> !cmd_o.in_ready)
    else $error("input accepted during store sweep");
`endif

endmodule

>>> rtl/triangle_raster_depth_test.sv
// Triangle rasterizer with depth test. A load word (tuser 0) latches three
// vertices. Each step word (tuser 1) tests the next pixel of the bounding
// box (x outer, y inner) and gives one result word; a covered pixel takes
// longer, as the shared one-bit-per-cycle divider forms three weights, three
// depth reciprocals and the final depth. A step with no active scan answers
// with an all-zero word with tlast set. A clear word (tuser 2) sweeps the
// 2,097,152-entry depth store one entry a cycle; the same sweep runs after
// reset, and no word is accepted meanwhile (register writes are). A finished
// result waits in an output register while the next word is accepted.
module triangle_raster_depth_test (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz
  input  logic [191:0] s_tdata,
  // operation
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pixel_x, pixel_y, covered, depth_pass, frag_depth, weight_a, weight_b,
  // weight_c, 3 zero bits
  output logic [111:0] m_tdata,
  // done_res
  output logic         m_tlast
);

  logic [11:0]    fw_q;
  logic [10:0]    fh_q;
  trdt_pkg::cmd_t cmd;
  trdt_pkg::sts_t sts;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= trdt_pkg::FW_RESET;
      fh_q <= trdt_pkg::FH_RESET;
    end else if (wr) begin
      if (paddr[2] == trdt_pkg::REG_FRAME_WIDTH) fw_q <= pwdata[11:0];
      if (paddr[2] == trdt_pkg::REG_FRAME_HEIGHT) fh_q <= pwdata[10:0];
    end
  end

  assign prdata = (paddr[2] == trdt_pkg::REG_FRAME_HEIGHT) ? {21'd0, fh_q} : {20'd0, fw_q};

  trdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .op_i       (s_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trdt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_data_i      (s_tdata),
    .frame_width_i  (fw_q),
    .frame_height_i (fh_q),
    .out_ready_i    (m_tready),
    .out_valid_o    (m_tvalid),
    .out_data_o     (m_tdata),
    .out_last_o     (m_tlast)
  );

  assign s_tready = cmd.in_ready;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int  WATCH_LIMIT = 8000000;
  localparam int  SETTLE      = 400;

  typedef struct {
    trdt_pkg::op_e     op;
    logic signed [15:0] x[3];
    logic signed [15:0] y[3];
    logic [31:0]       z[3];
  } tri_word_t;

  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
    logic        cov;
    logic        pass;
    logic [31:0] depth;
    logic [16:0] wa;
    logic [16:0] wb;
    logic [16:0] wc;
    logic        last;
  } pix_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic         m_tlast;

  triangle_raster_depth_test i_dut (.*);

  always #4 clk_i = ~clk_i;

  // pixel predictor state
  longint          vx[3], vy[3];
  longint unsigned vz[3];
  longint unsigned area2;
  longint          box_x0, box_y0, box_xmax, box_ymax, cur_x, cur_y;
  bit              scan_on;
  int unsigned     zbuf[int];
  longint unsigned fw = 1280, fh = 720;

  tri_word_t pending_words[$];
  pix_t      expected_pixels[$];
  tri_word_t cur_word;
  int        errors = 0;
  int        in_gap = 0, out_gap = 0;
  bit        calm = 0;
  int        idle_cnt = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint edge_val(int p, int q, longint px, longint py);
    return (vx[q] - vx[p]) * (py - vy[p]) - (vy[q] - vy[p]) * (px - vx[p]);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint trunc16(longint v);
    return v >= 0 ? v / 16 : -((-v) / 16);
  endfunction

  task automatic latch_triangle(tri_word_t w);
    longint mx, my;
    for (int i = 0; i < 3; i++) begin
      vx[i] = w.x[i];
      vy[i] = w.y[i];
      vz[i] = (w.z[i] == 0) ? 1 : w.z[i];
    end
    area2 = mag(edge_val(0, 1, vx[2], vy[2]));
    mx = vx[0] < vx[1] ? vx[0] : vx[1];
    mx = mx < vx[2] ? mx : vx[2];
    my = vy[0] < vy[1] ? vy[0] : vy[1];
    my = my < vy[2] ? my : vy[2];
    box_x0 = trunc16(mx);
    box_y0 = trunc16(my);
    box_xmax = vx[0] > vx[1] ? vx[0] : vx[1];
    box_xmax = box_xmax > vx[2] ? box_xmax : vx[2];
    box_ymax = vy[0] > vy[1] ? vy[0] : vy[1];
    box_ymax = box_ymax > vy[2] ? box_ymax : vy[2];
    cur_x = box_x0;
    cur_y = box_y0;
    scan_on = (box_x0 * 16 < box_xmax) && (box_y0 * 16 < box_ymax);
  endtask

  task automatic raster_pixel(output pix_t r);
    longint x, y, e_ab, e_bc, e_ca;
    longint unsigned w[3], s, d, idx, old;
    bit cov;
    r = '{default: 0};
    if (!scan_on) begin
      r.last = 1'b1;
      return;
    end
    x = cur_x;
    y = cur_y;
    e_ab = edge_val(0, 1, x * 16, y * 16);
    e_bc = edge_val(1, 2, x * 16, y * 16);
    e_ca = edge_val(2, 0, x * 16, y * 16);
    cov = (e_ab > 0 && e_bc > 0 && e_ca > 0) || (e_ab < 0 && e_bc < 0 && e_ca < 0);
    r.px = 12'(x);
    r.py = 12'(y);
    if (cov && area2 != 0) begin
      w[0] = (mag(e_bc) << 16) / area2;
      w[1] = (mag(e_ca) << 16) / area2;
      w[2] = (mag(e_ab) << 16) / area2;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        if (w[i] > 65536) w[i] = 65536;
        s += (w[i] << 32) / vz[i];
      end
      if (s == 0) d = 64'hFFFF_FFFF;
      else begin
        d = (64'd1 << 48) / s;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
        if (d == 0) d = 1;
      end
      r.cov = 1'b1;
      r.depth = 32'(d);
      r.wa = 17'(w[0]);
      r.wb = 17'(w[1]);
      r.wc = 17'(w[2]);
      if (x >= 0 && y >= 0 && longint'(x) < longint'(fw) &&
          longint'(y) < longint'(fh)) begin
        idx = longint'(y) * fw + longint'(x);
        if (idx < trdt_pkg::STORE_SIZE) begin
          old = zbuf.exists(int'(idx)) ? zbuf[int'(idx)] : 0;
          if (old == 0 || old > d) begin
            zbuf[int'(idx)] = 32'(d);
            r.pass = 1'b1;
          end
        end
      end
    end
    if ((y + 1) * 16 < box_ymax) cur_y = y + 1;
    else begin
      cur_y = box_y0;
      if ((x + 1) * 16 < box_xmax) cur_x = x + 1;
      else begin
        scan_on = 0;
        r.last = 1'b1;
      end
    end
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // input word driver
  always @(posedge clk_i or negedge rst_ni) begin
    pix_t r;
    bit   take;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        case (cur_word.op)
          trdt_pkg::OP_LOAD:  latch_triangle(cur_word);
          trdt_pkg::OP_STEP: begin
            raster_pixel(r);
            expected_pixels = {expected_pixels, r};
          end
          trdt_pkg::OP_CLEAR: zbuf.delete();
          default: ;
        endcase
      end
      take = 0;
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_words.size() > 0) take = 1;
        if (take) begin
          cur_word = pending_words.pop_front();
          s_tdata <= {cur_word.z[2], cur_word.y[2], cur_word.x[2],
                      cur_word.z[1], cur_word.y[1], cur_word.x[1],
                      cur_word.z[0], cur_word.y[0], cur_word.x[0]};
          s_tuser <= cur_word.op;
          in_gap <= pick_gap();
        end
        s_tvalid <= take;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pix_t e;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("result word with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (m_tdata[11:0] !== e.px) report("pixel_x", m_tdata[11:0], e.px);
          if (m_tdata[23:12] !== e.py) report("pixel_y", m_tdata[23:12], e.py);
          if (m_tdata[24] !== e.cov) report("covered", m_tdata[24], e.cov);
          if (m_tdata[25] !== e.pass) report("depth_pass", m_tdata[25], e.pass);
          if (m_tdata[57:26] !== e.depth) report("frag_depth", m_tdata[57:26], e.depth);
          if (m_tdata[74:58] !== e.wa) report("weight_a", m_tdata[74:58], e.wa);
          if (m_tdata[91:75] !== e.wb) report("weight_b", m_tdata[91:75], e.wb);
          if (m_tdata[108:92] !== e.wc) report("weight_c", m_tdata[108:92], e.wc);
          if (m_tlast !== e.last) report("done_res", m_tlast, e.last);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) out_gap <= pick_gap();
      end
    end
  end

  // watchdog, the clearing sweep counts as silence
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCH_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  int        n_items = 0;
  tri_word_t last_tri;

  function automatic tri_word_t noise_word(trdt_pkg::op_e op);
    tri_word_t w;
    w.op = op;
    for (int i = 0; i < 3; i++) begin
      w.x[i] = 16'($urandom);
      w.y[i] = 16'($urandom);
      w.z[i] = $urandom;
    end
    return w;
  endfunction

  function automatic logic [31:0] rand_depth();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 5) return $urandom_range(1, 32'h0004_0000);
    return $urandom;
  endfunction

  task automatic push(tri_word_t w);
    pending_words = {pending_words, w};
    if (w.op != trdt_pkg::OP_NONE) n_items++;
  endtask

  task automatic push_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                          logic [31:0] z0, logic [31:0] z1, logic [31:0] z2);
    tri_word_t w;
    w = noise_word(trdt_pkg::OP_LOAD);
    w.x[0] = 16'(x0); w.y[0] = 16'(y0); w.z[0] = z0;
    w.x[1] = 16'(x1); w.y[1] = 16'(y1); w.z[1] = z1;
    w.x[2] = 16'(x2); w.y[2] = 16'(y2); w.z[2] = z2;
    last_tri = w;
    push(w);
  endtask

  task automatic push_steps(int n);
    repeat (n) push(noise_word(trdt_pkg::OP_STEP));
  endtask

  function automatic int near_base(longint unsigned lim);
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 40) - 8;
    return int'(lim) - 4 + $urandom_range(0, 6);
  endfunction

  task automatic push_sequence();
    tri_word_t w;
    int r, bx, by, sz;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      push(noise_word(trdt_pkg::OP_LOAD));
      push_steps($urandom_range(0, 3));
    end else if (r < 11) begin
      push(noise_word(trdt_pkg::OP_NONE));
    end else if (r < 14) begin
      push_steps($urandom_range(1, 2));
    end else begin
      if (r < 38 && n_items > 0) begin
        // same triangle again, new depths exercise the depth test
        w = last_tri;
        for (int i = 0; i < 3; i++) w.z[i] = rand_depth();
        push(w);
        last_tri = w;
      end else begin
        bx = near_base(fw);
        by = near_base(fh);
        if (bx > 2040) bx = 2040;
        if (by > 2040) by = 2040;
        sz = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        w = noise_word(trdt_pkg::OP_LOAD);
        for (int i = 0; i < 3; i++) begin
          w.x[i] = 16'(bx * 16 + $urandom_range(0, sz * 16));
          w.y[i] = 16'(by * 16 + $urandom_range(0, sz * 16));
          w.z[i] = rand_depth();
        end
        if ($urandom_range(0, 19) == 0) begin
          // collinear vertices
          w.x[2] = w.x[0] + (w.x[1] - w.x[0]) * 2;
          w.y[2] = w.y[0] + (w.y[1] - w.y[0]) * 2;
        end
        last_tri = w;
        push(w);
        sz = sz + 1;
      end
      push_steps($urandom_range(1, 40));
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == trdt_pkg::REG_FRAME_WIDTH) fw = v & 32'hFFF;
    else fh = v & 32'h7FF;
  endtask

  task automatic set_frame(int w, int h);
    drain();
    reg_write(trdt_pkg::REG_FRAME_WIDTH, w);
    reg_write(trdt_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic random_phase(int target);
    int stop;
    stop = n_items + target;
    calm = 0;
    while (n_items < stop) begin
      if (n_items > stop - target / 4) calm = 1;
      push_sequence();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: step with no scan, unknown op, small triangle, depth retest
    push_steps(1);
    push(noise_word(trdt_pkg::OP_NONE));
    push_tri(0, 0, 48, 0, 0, 48, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    push_steps(10);
    push_tri(0, 0, 48, 0, 0, 48, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    push_steps(3);
    // load during a scan restarts it; zero and maximal depths
    push_tri(8, 8, 56, 24, 24, 56, 32'd0, 32'hFFFF_FFFF, 32'd1);
    push_steps(5);
    push_tri(0, 0, 32, 32, 64, 64, 32'h1000, 32'h1000, 32'h1000);
    push_steps(2);
    push_tri(-32768, -32768, 32767, -32768, 0, 32767, 32'd5, 32'd7, 32'd9);
    push_steps(2);
    random_phase(200);

    set_frame(1, 1);
    random_phase(240);
    set_frame(37, 19);
    random_phase(240);
    set_frame(640, 480);
    random_phase(240);
    set_frame(2048, 1024);
    random_phase(240);

    // clear in the middle of a scan, then redraw on an empty store
    drain();
    push_tri(16, 16, 96, 16, 16, 96, 32'h2000, 32'h2000, 32'h2000);
    push_steps(8);
    push(noise_word(trdt_pkg::OP_CLEAR));
    push_steps(18);
    push_tri(16, 16, 96, 16, 16, 96, 32'h2000, 32'h2000, 32'h2000);
    push_steps(26);
    random_phase(200);

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
